// File: rtl/ccss_pkg.sv
// shared codes, constants and helper functions for the cluster chain sector sequencer
package ccss_pkg;

   localparam logic [1:0] OP_START      = 2'd0;
   localparam logic [1:0] OP_DATA_DONE  = 2'd1;
   localparam logic [1:0] OP_FAT_WORD   = 2'd2;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_FAT      = 2'd1;
   localparam logic [1:0] KIND_FINISH   = 2'd2;

   localparam logic [1:0] FIN_ALL_READ  = 2'd0;
   localparam logic [1:0] FIN_END_CHAIN = 2'd1;
   localparam logic [1:0] FIN_BAD       = 2'd2;
   localparam logic [1:0] FIN_DEV_ERROR = 2'd3;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_DATA    = 2'd1;
   localparam logic [1:0] PHASE_FAT     = 2'd2;

   localparam logic [1:0] CSR_DATA_START = 2'd0;
   localparam logic [1:0] CSR_FAT_START  = 2'd1;
   localparam logic [1:0] CSR_SPC        = 2'd2;

   localparam logic [27:0] FAT_EOC_MIN  = 28'hFFFFFF8;
   localparam logic [27:0] FAT_BAD      = 28'hFFFFFF7;

   localparam logic [31:0] SECTOR_BYTES = 32'd512;
   localparam logic [7:0]  SPC_MAX      = 8'd128;
   localparam logic [7:0]  SPC_RESET    = 8'd8;

   typedef struct packed {
      logic [1:0]  request_kind;
      logic [31:0] sector_lba;
      logic [9:0]  copy_bytes;
      logic [31:0] dest_offset;
      logic [8:0]  fat_byte_index;
      logic [1:0]  finish_code;
   } rsp_type;

   function automatic logic [7:0] eff_spc(input logic [7:0] spc);
      logic [7:0] r;
      r = spc;
      if (spc == 8'd0) r = 8'd1;
      else if (spc > SPC_MAX) r = SPC_MAX;
      return r;
   endfunction

   function automatic logic [9:0] copy_size(input logic [31:0] remaining);
      logic [9:0] r;
      r = (remaining > SECTOR_BYTES) ? SECTOR_BYTES[9:0] : remaining[9:0];
      return r;
   endfunction

endpackage

// File: rtl/cluster_chain_sector_sequencer_top.sv
// cluster chain sector sequencer: walks a fat32 cluster chain and issues sector requests
//
// An accepted item is held in the input register, is decided by one pass of logic
// (one 32x8 multiply for the cluster address, plus adds and compares) and its result, if
// any, is loaded into the output register that drives rsp_valid. A new item can be taken
// every cycle while the output register is free or being emptied.
// Configuration must be written only while no walk step is in flight.
module cluster_chain_sector_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [27:0] req_first_cluster,
   input  logic [31:0] req_file_size,
   input  logic [31:0] req_file_offset,
   input  logic [31:0] req_byte_request,
   input  logic [31:0] req_fat_word,
   input  logic        req_device_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_request_kind,
   output logic [31:0] rsp_sector_lba,
   output logic [9:0]  rsp_copy_bytes,
   output logic [31:0] rsp_dest_offset,
   output logic [8:0]  rsp_fat_byte_index,
   output logic [1:0]  rsp_finish_code,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   // configuration
   logic [31:0] data_start_ff;
   logic [31:0] fat_start_ff;
   logic [7:0]  spc_ff;

   // input register
   logic        in_valid_ff;
   logic [1:0]  op_ff;
   logic [27:0] first_cluster_ff;
   logic [31:0] file_size_ff;
   logic [31:0] file_offset_ff;
   logic [31:0] byte_request_ff;
   logic [31:0] fat_word_ff;
   logic        dev_err_ff;

   // walk state
   logic [1:0]  phase_ff, phase_in;
   logic [27:0] cluster_ff, cluster_in;
   logic [6:0]  sic_ff, sic_in;
   logic [31:0] lba_ff, lba_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] done_ff, done_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   ccss_pkg::rsp_type    rsp_ff, rsp_in;

   logic        out_blocked;
   logic        advance;
   logic        has_result;
   logic [7:0]  spc;
   logic [27:0] next_cluster;
   logic [27:0] addr_cluster;
   logic [31:0] cl_minus2;
   logic [39:0] prod;
   logic [31:0] cluster_lba;
   logic [31:0] left;
   logic [31:0] start_rem;
   logic [9:0]  copy;
   logic [31:0] rem_after;
   logic [31:0] done_after;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = in_valid_ff && out_blocked;
   assign advance     = in_valid_ff && !out_blocked;

   assign spc          = ccss_pkg::eff_spc(spc_ff);
   assign next_cluster = fat_word_ff[27:0];
   assign addr_cluster = (op_ff == ccss_pkg::OP_START) ? first_cluster_ff : next_cluster;
   assign cl_minus2    = {4'b0, addr_cluster} - 32'd2;
   assign prod         = {8'b0, cl_minus2} * {32'b0, spc};
   assign cluster_lba  = data_start_ff + prod[31:0];

   assign left       = (file_size_ff > file_offset_ff) ? (file_size_ff - file_offset_ff) : 32'd0;
   assign start_rem  = (byte_request_ff < left) ? byte_request_ff : left;
   assign copy       = ccss_pkg::copy_size(rem_ff);
   assign rem_after  = rem_ff - {22'b0, copy};
   assign done_after = done_ff + {22'b0, copy};

   always_comb begin
      phase_in   = phase_ff;
      cluster_in = cluster_ff;
      sic_in     = sic_ff;
      lba_in     = lba_ff;
      rem_in     = rem_ff;
      done_in    = done_ff;
      has_result = 1'b0;
      rsp_in     = '0;
      case (op_ff)
         ccss_pkg::OP_START: begin
            has_result = 1'b1;
            rem_in     = start_rem;
            done_in    = 32'd0;
            cluster_in = first_cluster_ff;
            sic_in     = 7'd0;
            lba_in     = cluster_lba;
            if (start_rem == 32'd0) begin
               phase_in            = ccss_pkg::PHASE_IDLE;
               rsp_in.request_kind = ccss_pkg::KIND_FINISH;
               rsp_in.finish_code  = ccss_pkg::FIN_ALL_READ;
            end else begin
               phase_in            = ccss_pkg::PHASE_DATA;
               rsp_in.request_kind = ccss_pkg::KIND_DATA;
               rsp_in.sector_lba   = cluster_lba;
               rsp_in.copy_bytes   = ccss_pkg::copy_size(start_rem);
            end
         end
         ccss_pkg::OP_DATA_DONE: begin
            if (phase_ff == ccss_pkg::PHASE_DATA) begin
               has_result = 1'b1;
               if (dev_err_ff) begin
                  phase_in            = ccss_pkg::PHASE_IDLE;
                  rsp_in.request_kind = ccss_pkg::KIND_FINISH;
                  rsp_in.dest_offset  = done_ff;
                  rsp_in.finish_code  = ccss_pkg::FIN_DEV_ERROR;
               end else begin
                  rem_in             = rem_after;
                  done_in            = done_after;
                  rsp_in.dest_offset = done_after;
                  if (rem_after == 32'd0) begin
                     phase_in            = ccss_pkg::PHASE_IDLE;
                     rsp_in.request_kind = ccss_pkg::KIND_FINISH;
                     rsp_in.finish_code  = ccss_pkg::FIN_ALL_READ;
                  end else if (({1'b0, sic_ff} + 8'd1) < spc) begin
                     sic_in              = sic_ff + 7'd1;
                     lba_in              = lba_ff + 32'd1;
                     rsp_in.request_kind = ccss_pkg::KIND_DATA;
                     rsp_in.sector_lba   = lba_ff + 32'd1;
                     rsp_in.copy_bytes   = ccss_pkg::copy_size(rem_after);
                  end else begin
                     phase_in              = ccss_pkg::PHASE_FAT;
                     rsp_in.request_kind   = ccss_pkg::KIND_FAT;
                     rsp_in.sector_lba     = fat_start_ff + {11'b0, cluster_ff[27:7]};
                     rsp_in.fat_byte_index = {cluster_ff[6:0], 2'b00};
                  end
               end
            end
         end
         ccss_pkg::OP_FAT_WORD: begin
            if (phase_ff == ccss_pkg::PHASE_FAT) begin
               has_result         = 1'b1;
               rsp_in.dest_offset = done_ff;
               if (dev_err_ff) begin
                  phase_in            = ccss_pkg::PHASE_IDLE;
                  rsp_in.request_kind = ccss_pkg::KIND_FINISH;
                  rsp_in.finish_code  = ccss_pkg::FIN_DEV_ERROR;
               end else if (next_cluster >= ccss_pkg::FAT_EOC_MIN) begin
                  phase_in            = ccss_pkg::PHASE_IDLE;
                  rsp_in.request_kind = ccss_pkg::KIND_FINISH;
                  rsp_in.finish_code  = ccss_pkg::FIN_END_CHAIN;
               end else if (next_cluster == ccss_pkg::FAT_BAD) begin
                  phase_in            = ccss_pkg::PHASE_IDLE;
                  rsp_in.request_kind = ccss_pkg::KIND_FINISH;
                  rsp_in.finish_code  = ccss_pkg::FIN_BAD;
               end else begin
                  phase_in            = ccss_pkg::PHASE_DATA;
                  cluster_in          = next_cluster;
                  sic_in              = 7'd0;
                  lba_in              = cluster_lba;
                  rsp_in.request_kind = ccss_pkg::KIND_DATA;
                  rsp_in.sector_lba   = cluster_lba;
                  rsp_in.copy_bytes   = copy;
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (advance && has_result) || out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff <= 32'd0;
         fat_start_ff  <= 32'd0;
         spc_ff        <= ccss_pkg::SPC_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ccss_pkg::CSR_DATA_START: data_start_ff <= csr_write_data;
            ccss_pkg::CSR_FAT_START:  fat_start_ff  <= csr_write_data;
            ccss_pkg::CSR_SPC:        spc_ff        <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff            <= req_opcode;
         first_cluster_ff <= req_first_cluster;
         file_size_ff     <= req_file_size;
         file_offset_ff   <= req_file_offset;
         byte_request_ff  <= req_byte_request;
         fat_word_ff      <= req_fat_word;
         dev_err_ff       <= req_device_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ccss_pkg::PHASE_IDLE;
         cluster_ff <= 28'd0;
         sic_ff     <= 7'd0;
         lba_ff     <= 32'd0;
         rem_ff     <= 32'd0;
         done_ff    <= 32'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         cluster_ff <= cluster_in;
         sic_ff     <= sic_in;
         lba_ff     <= lba_in;
         rem_ff     <= rem_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_request_kind   = rsp_ff.request_kind;
   assign rsp_sector_lba     = rsp_ff.sector_lba;
   assign rsp_copy_bytes     = rsp_ff.copy_bytes;
   assign rsp_dest_offset    = rsp_ff.dest_offset;
   assign rsp_fat_byte_index = rsp_ff.fat_byte_index;
   assign rsp_finish_code    = rsp_ff.finish_code;

   // data requests always carry a nonzero copy of at most one sector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.request_kind == ccss_pkg::KIND_DATA) |->
         (rsp_ff.copy_bytes != 10'd0) && ({22'b0, rsp_ff.copy_bytes} <= ccss_pkg::SECTOR_BYTES))
      else $error("data request copy size out of range");

   // a fat request leaves the walk waiting for the fat word
   assert property (@(posedge clock) disable iff (reset)
      advance && has_result && (rsp_in.request_kind == ccss_pkg::KIND_FAT) |=>
         (phase_ff == ccss_pkg::PHASE_FAT))
      else $error("fat request without fat phase");

   // a finish result returns the walk to idle
   assert property (@(posedge clock) disable iff (reset)
      advance && has_result && (rsp_in.request_kind == ccss_pkg::KIND_FINISH) |=>
         (phase_ff == ccss_pkg::PHASE_IDLE))
      else $error("finish without idle phase");

   // input side only stalls while both registers are full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("stall with free pipeline");

   // byte progress never goes backward within a walk
   assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == ccss_pkg::OP_DATA_DONE) |=> (done_ff >= $past(done_ff)))
      else $error("bytes done decreased");

endmodule
